// ===== design/button_sequence_detector_top_assert.svh =====
// Assertion macros for the button sequence detector.
`ifndef BUTTON_SEQUENCE_DETECTOR_TOP_ASSERT_SVH
`define BUTTON_SEQUENCE_DETECTOR_TOP_ASSERT_SVH

// Same-cycle implication, disabled while in reset.
`define BSD_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while in reset.
`define BSD_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== design/bsd_pkg.sv =====
`default_nettype none

package bsd_pkg;

  localparam int CODE_W = 32;
  localparam int POS_W  = 5;
  localparam int SLOT_W = 4;
  localparam int CFG_W  = 32;
  localparam int CFG_IDX_W = 2;

  typedef enum logic [1:0] {
    OP_TICK   = 2'd0,
    OP_PRESS  = 2'd1,
    OP_LOAD   = 2'd2,
    OP_UNUSED = 2'd3
  } opcode_t;

  localparam logic [CFG_IDX_W-1:0] REG_SEQ_LENGTH    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_MASK_COMPARE  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_TIMEOUT_TICKS = 2'd2;

  localparam logic [POS_W-1:0]  SEQ_LENGTH_RST    = 5'd1;
  localparam logic              MASK_COMPARE_RST  = 1'b0;
  localparam logic [CFG_W-1:0]  TIMEOUT_TICKS_RST = 32'd2000;
  localparam logic [CFG_W-1:0]  TICKS_MAX         = '1;

  typedef struct packed {
    logic [1:0]        opcode;
    logic [CODE_W-1:0] button_code;
    logic [SLOT_W-1:0] entry_index;
  } cmd_item_t;

  typedef struct packed {
    logic             completed;
    logic [POS_W-1:0] position;
  } rsp_item_t;

  typedef struct packed {
    logic [POS_W-1:0] seq_length;
    logic             mask_compare;
    logic [CFG_W-1:0] timeout_ticks;
  } cfg_t;

endpackage

`default_nettype wire

// ===== design/bsd_engine.sv =====
`default_nettype none

module bsd_engine #(
  parameter int MAX_SEQ_LEN = 16
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              step,
  input  wire bsd_pkg::cmd_item_t item,
  input  wire bsd_pkg::cfg_t      cfg,
  output bsd_pkg::rsp_item_t      result
);
  import bsd_pkg::*;

  // At most 16 slots can ever be loaded; deeper entries are never written.
  localparam int TBL_DEPTH = (MAX_SEQ_LEN < (1 << SLOT_W)) ? MAX_SEQ_LEN : (1 << SLOT_W);
  localparam int IDX_W     = (TBL_DEPTH > 1) ? $clog2(TBL_DEPTH) : 1;
  localparam int TBL_SLOTS = 1 << IDX_W;
  localparam int CAP_INT   = (MAX_SEQ_LEN > ((1 << POS_W) - 1)) ? ((1 << POS_W) - 1)
                                                               : MAX_SEQ_LEN;
  localparam logic [POS_W-1:0] LEN_CAP = POS_W'(CAP_INT);

  logic [CODE_W-1:0] seq_table [TBL_SLOTS];
  logic [POS_W-1:0]  position;
  logic [CFG_W-1:0]  ticks;

  logic [POS_W-1:0]  position_next;
  logic [CFG_W-1:0]  ticks_next;
  logic              done;
  logic [POS_W-1:0]  len;
  logic [POS_W-1:0]  pos;
  logic [POS_W-1:0]  pos_inc;
  logic [CODE_W-1:0] expected;
  logic [CODE_W-1:0] first;
  logic              hit_cur;
  logic              hit_first;
  logic              load_ok;

  function automatic logic code_match(input logic [CODE_W-1:0] pressed,
                                      input logic [CODE_W-1:0] exp_code,
                                      input logic              use_mask);
    logic r;
    r = use_mask ? ((pressed & exp_code) == exp_code) : (pressed == exp_code);
    return r;
  endfunction

  always_comb begin
    if (cfg.seq_length == '0) begin
      len = POS_W'(1);
    end else if (cfg.seq_length > LEN_CAP) begin
      len = LEN_CAP;
    end else begin
      len = cfg.seq_length;
    end
  end

  assign pos       = (position >= len) ? '0 : position;
  assign pos_inc   = pos + POS_W'(1);
  assign expected  = seq_table[pos[IDX_W-1:0]];
  assign first     = seq_table[0];
  assign hit_cur   = code_match(item.button_code, expected, cfg.mask_compare);
  assign hit_first = code_match(item.button_code, first, cfg.mask_compare);
  assign load_ok   = (int'(item.entry_index) < MAX_SEQ_LEN);

  always_comb begin
    position_next = position;
    ticks_next    = ticks;
    done          = 1'b0;
    unique case (opcode_t'(item.opcode))
      OP_TICK: begin
        if (ticks != TICKS_MAX) begin
          ticks_next = ticks + CFG_W'(1);
        end
      end
      OP_PRESS: begin
        ticks_next = '0;
        if (!hit_cur) begin
          if (hit_first) begin
            if (len == POS_W'(1)) begin
              position_next = '0;
              done          = 1'b1;
            end else begin
              position_next = POS_W'(1);
            end
          end else begin
            position_next = '0;
          end
        end else if ((pos != '0) && (ticks > cfg.timeout_ticks)) begin
          position_next = '0;
        end else if (pos_inc >= len) begin
          position_next = '0;
          done          = 1'b1;
        end else begin
          position_next = pos_inc;
        end
      end
      OP_LOAD, OP_UNUSED: begin
      end
      default: begin
      end
    endcase
  end

  assign result.completed = done;
  assign result.position  = position_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      position <= '0;
      ticks    <= '0;
    end else if (step) begin
      position <= position_next;
      ticks    <= ticks_next;
    end
  end

  always_ff @(posedge clk) begin
    if (step && (opcode_t'(item.opcode) == OP_LOAD) && load_ok) begin
      seq_table[item.entry_index[IDX_W-1:0]] <= item.button_code;
    end
  end

endmodule

`default_nettype wire

// ===== design/button_sequence_detector_top.sv =====
// channel  | handshake               | payload
// cmd      | cmd_valid / cmd_stall   | cmd  (opcode, button_code, entry_index)
// rsp      | rsp_valid / rsp_stall   | rsp  (completed, position)
// cfg      | cfg_we                  | cfg_index, cfg_data
//
// An accepted item is loaded into the input register; when it advances, the
// result register is loaded from the compare and position update. One item
// per cycle sustained while the result register is not stalled.
// Synchronous reset clears position, tick count and valids, presets config;
// the code table is not reset. A stalled result holds; one more item may
// enter the input register behind it before cmd_stall rises.
`default_nettype none

module button_sequence_detector_top #(
  parameter int MAX_SEQ_LEN = 16
) (
  input  wire logic                             clk,
  input  wire logic                             rst,
  input  wire logic                             cmd_valid,
  output logic                                  cmd_stall,
  input  wire bsd_pkg::cmd_item_t               cmd,
  output logic                                  rsp_valid,
  input  wire logic                             rsp_stall,
  output bsd_pkg::rsp_item_t                    rsp,
  input  wire logic                             cfg_we,
  input  wire logic [bsd_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  wire logic [bsd_pkg::CFG_W-1:0]        cfg_data
);
  import bsd_pkg::*;

  cfg_t      cfg;
  cmd_item_t s1_item;
  logic      s1_valid;
  logic      advance;
  rsp_item_t result;

  assign advance   = s1_valid && (!rsp_valid || !rsp_stall);
  assign cmd_stall = s1_valid && rsp_valid && rsp_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.seq_length    <= SEQ_LENGTH_RST;
      cfg.mask_compare  <= MASK_COMPARE_RST;
      cfg.timeout_ticks <= TIMEOUT_TICKS_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_SEQ_LENGTH:    cfg.seq_length    <= cfg_data[POS_W-1:0];
        REG_MASK_COMPARE:  cfg.mask_compare  <= cfg_data[0];
        REG_TIMEOUT_TICKS: cfg.timeout_ticks <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (!cmd_stall) begin
      s1_valid <= cmd_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd_valid && !cmd_stall) begin
      s1_item <= cmd;
    end
  end

  bsd_engine #(
    .MAX_SEQ_LEN(MAX_SEQ_LEN)
  ) u_engine (
    .clk    (clk),
    .rst    (rst),
    .step   (advance),
    .item   (s1_item),
    .cfg    (cfg),
    .result (result)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (advance) begin
      rsp_valid <= 1'b1;
    end else if (!rsp_stall) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      rsp <= result;
    end
  end

`include "button_sequence_detector_top_assert.svh"

  `BSD_ASSERT_NOW(a_done_pos_zero, rsp_valid && rsp.completed, rsp.position == '0,
                  "completed item must leave position at zero")
  `BSD_ASSERT_NEXT(a_accept_fills, cmd_valid && !cmd_stall, s1_valid,
                   "accepted item missing from input register")
  `BSD_ASSERT_NOW(a_no_stall_empty, !rsp_valid, !cmd_stall,
                  "input stalled while result register empty")

endmodule

`default_nettype wire
